@@ design/rpzp_pkg.sv @@
// Shared constants, types and glyph lookup for the rotate/project/z-buffer plotter.
package rpzp_pkg;

  localparam int MAX_CELLS = 8192;
  localparam int ADDR_W    = $clog2(MAX_CELLS);
  localparam int IDX_W     = 16;

  localparam int A_W   = 18;
  localparam int B_W   = 17;
  localparam int ACC_W = A_W + B_W + 2;

  localparam int DVD_W = 25;
  localparam int DVS_W = 16;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_COS_FIRST     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN_FIRST     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COS_SECOND    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN_SECOND    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_COLS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_ROWS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_DISTANCE = 3'd6;

  localparam logic [7:0] GLYPH_BLANK = 8'd32;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic clr;
    logic sub;
  } mac_ctrl_t;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wr_glyph;
    logic [15:0]       wr_depth;
  } store_req_t;

  function automatic logic [7:0] glyph_of(input logic [2:0] face);
    logic [7:0] g;
    case (face)
      3'd0:    g = 8'h2E;
      3'd1:    g = 8'h3A;
      3'd2:    g = 8'h2D;
      3'd3:    g = 8'h3D;
      3'd4:    g = 8'h2B;
      3'd5:    g = 8'h2A;
      3'd6:    g = 8'h23;
      default: g = 8'h25;
    endcase
    return g;
  endfunction

endpackage

@@ design/rpzp_mac.sv @@
// Shared signed multiply-accumulate unit with a registered product.
module rpzp_mac import rpzp_pkg::*; (
  input  logic                    clk,
  input  mac_ctrl_t               ctrl,
  input  logic signed [A_W-1:0]   a,
  input  logic signed [B_W-1:0]   b,
  output logic signed [ACC_W-1:0] acc
);

  logic signed [A_W+B_W-1:0] prod;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [ACC_W-1:0]   base;

  assign prod_ext = ACC_W'(prod);
  assign base     = ctrl.clr ? '0 : acc;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= a * b;
    end
    if (ctrl.acc_en) begin
      acc <= ctrl.sub ? (base - prod_ext) : (base + prod_ext);
    end
  end

endmodule

@@ design/rpzp_div.sv @@
// Restoring divider, one quotient bit per cycle.
module rpzp_div import rpzp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W);

  logic             running;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] den;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;

  assign shifted  = {rem, quotient[DVD_W-1]};
  assign diff     = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(DVD_W - 1);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      den      <= divisor;
      quotient <= dividend;
    end else if (running) begin
      if (!diff[DVS_W]) begin
        rem      <= diff[DVS_W-1:0];
        quotient <= {quotient[DVD_W-2:0], 1'b1};
      end else begin
        rem      <= shifted[DVS_W-1:0];
        quotient <= {quotient[DVD_W-2:0], 1'b0};
      end
    end
  end

endmodule

@@ design/rpzp_store.sv @@
// Glyph and depth memories with a clearing sweep after reset.
module rpzp_store import rpzp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  store_req_t req,
  output logic       init_busy,
  output logic [7:0] rd_glyph,
  output logic [15:0] rd_depth
);

  logic [7:0]        glyph_mem [MAX_CELLS];
  logic [15:0]       depth_mem [MAX_CELLS];
  logic [ADDR_W-1:0] clr_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_glyph;
  logic [15:0]       wr_depth;

  assign wr_en    = init_busy || req.wr_en;
  assign wr_addr  = init_busy ? clr_addr : req.addr;
  assign wr_glyph = init_busy ? GLYPH_BLANK : req.wr_glyph;
  assign wr_depth = init_busy ? 16'd0 : req.wr_depth;

  always_ff @(posedge clk) begin
    if (rst) begin
      init_busy <= 1'b1;
      clr_addr  <= '0;
    end else if (init_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_W'(MAX_CELLS - 1)) begin
        init_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      glyph_mem[wr_addr] <= wr_glyph;
      depth_mem[wr_addr] <= wr_depth;
    end
    if (req.rd_en) begin
      rd_glyph <= glyph_mem[req.addr];
      rd_depth <= depth_mem[req.addr];
    end
  end

endmodule

@@ design/rotate_project_zbuffer_plot.sv @@
// Top level: sequencer driving the shared MAC, the divider and the cell store.
// A read item reads the cell in S_READ_RD and gives its result in S_READ_OUT, and busy
// drops the cycle after. A plot item holds busy through 13 multiply-accumulate steps on
// one multiplier and three bit-serial divisions; it ends early when dropped.
// One item at a time; the result strobe lasts one cycle and the receiver cannot stall.
// After reset a clearing sweep over all MAX_CELLS cells runs with busy high.
module rotate_project_zbuffer_plot import rpzp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 cmd,
  input  logic signed [12:0]   point_x,
  input  logic signed [12:0]   point_y,
  input  logic signed [12:0]   point_z,
  input  logic [2:0]           face,
  input  logic [12:0]          cell_index,
  output logic                 result_strobe,
  output logic [7:0]           glyph,
  output logic [15:0]          depth_value,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_MUL      = 4'd1;
  localparam logic [3:0] S_ACC      = 4'd2;
  localparam logic [3:0] S_POST     = 4'd3;
  localparam logic [3:0] S_DIV      = 4'd4;
  localparam logic [3:0] S_PLOT_RD  = 4'd5;
  localparam logic [3:0] S_PLOT_CMP = 4'd6;
  localparam logic [3:0] S_READ_RD  = 4'd7;
  localparam logic [3:0] S_READ_OUT = 4'd8;

  localparam logic [3:0] STEP_Y1_A  = 4'd0;
  localparam logic [3:0] STEP_Y1_B  = 4'd1;
  localparam logic [3:0] STEP_Z1_A  = 4'd2;
  localparam logic [3:0] STEP_Z1_B  = 4'd3;
  localparam logic [3:0] STEP_X2_A  = 4'd4;
  localparam logic [3:0] STEP_X2_B  = 4'd5;
  localparam logic [3:0] STEP_Z2_A  = 4'd6;
  localparam logic [3:0] STEP_Z2_B  = 4'd7;
  localparam logic [3:0] STEP_COL_A = 4'd8;
  localparam logic [3:0] STEP_COL_B = 4'd9;
  localparam logic [3:0] STEP_ROW_A = 4'd10;
  localparam logic [3:0] STEP_ROW_B = 4'd11;
  localparam logic [3:0] STEP_IDX   = 4'd12;

  logic signed [15:0] cos_first;
  logic signed [15:0] sin_first;
  logic signed [15:0] cos_second;
  logic signed [15:0] sin_second;
  logic [7:0]         screen_cols;
  logic [6:0]         screen_rows;
  logic [5:0]         view_distance;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [3:0] step;

  logic signed [12:0] px;
  logic signed [12:0] py;
  logic signed [12:0] pz;
  logic [2:0]         face_r;
  logic signed [15:0] y1;
  logic signed [15:0] z1;
  logic signed [16:0] x2;
  logic signed [17:0] zv;
  logic [15:0]        inv;
  logic [7:0]         col;
  logic [6:0]         row;
  logic               neg;
  logic [ADDR_W-1:0]  addr;
  logic               oor;

  mac_ctrl_t               mac_ctrl;
  logic signed [A_W-1:0]   mac_a;
  logic signed [B_W-1:0]   mac_b;
  logic signed [ACC_W-1:0] acc;

  logic             div_start;
  logic [DVD_W-1:0] div_dividend;
  logic [DVS_W-1:0] div_divisor;
  logic             div_done;
  logic [DVD_W-1:0] div_q;

  store_req_t  store_req;
  logic        init_busy;
  logic [7:0]  rd_glyph;
  logic [15:0] rd_depth;

  logic signed [17:0] zv_now;
  logic               zv_pos;
  logic               neg_now;
  logic [DVD_W-1:0]   mag_now;
  logic [IDX_W-1:0]   idx_now;
  logic [IDX_W-1:0]   cell_idx;
  logic               is_b_step;
  logic               q_zero;
  logic               col_ok;
  logic               row_ok;
  logic               accept;
  logic               plot_hit;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE) || init_busy;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_first     <= 16'sd16384;
      sin_first     <= 16'sd0;
      cos_second    <= 16'sd16384;
      sin_second    <= 16'sd0;
      screen_cols   <= 8'd80;
      screen_rows   <= 7'd24;
      view_distance <= 6'd30;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COS_FIRST:     cos_first     <= cfg_data;
        CFG_SIN_FIRST:     sin_first     <= cfg_data;
        CFG_COS_SECOND:    cos_second    <= cfg_data;
        CFG_SIN_SECOND:    sin_second    <= cfg_data;
        CFG_SCREEN_COLS:   screen_cols   <= cfg_data[7:0];
        CFG_SCREEN_ROWS:   screen_rows   <= cfg_data[6:0];
        CFG_VIEW_DISTANCE: view_distance <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (step)
      STEP_Y1_A:  begin mac_a = A_W'(py); mac_b = B_W'(cos_first);  end
      STEP_Y1_B:  begin mac_a = A_W'(pz); mac_b = B_W'(sin_first);  end
      STEP_Z1_A:  begin mac_a = A_W'(py); mac_b = B_W'(sin_first);  end
      STEP_Z1_B:  begin mac_a = A_W'(pz); mac_b = B_W'(cos_first);  end
      STEP_X2_A:  begin mac_a = A_W'(px); mac_b = B_W'(cos_second); end
      STEP_X2_B:  begin mac_a = A_W'(z1); mac_b = B_W'(sin_second); end
      STEP_Z2_A:  begin mac_a = A_W'(z1); mac_b = B_W'(cos_second); end
      STEP_Z2_B:  begin mac_a = A_W'(px); mac_b = B_W'(sin_second); end
      STEP_COL_A: begin mac_a = zv; mac_b = B_W'(signed'({1'b0, screen_cols[7:1]})); end
      STEP_COL_B: begin mac_a = A_W'(x2); mac_b = B_W'(80); end
      STEP_ROW_A: begin mac_a = zv; mac_b = B_W'(signed'({1'b0, screen_rows[6:1]})); end
      STEP_ROW_B: begin mac_a = A_W'(y1); mac_b = B_W'(20); end
      STEP_IDX:   begin
        mac_a = A_W'(signed'({1'b0, row}));
        mac_b = B_W'(signed'({1'b0, screen_cols}));
      end
      default:    begin mac_a = '0; mac_b = '0; end
    endcase
  end

  always_comb begin
    case (step)
      STEP_Y1_B, STEP_Z1_B, STEP_X2_B, STEP_Z2_B,
      STEP_COL_B, STEP_ROW_B, STEP_IDX: is_b_step = 1'b1;
      default:                          is_b_step = 1'b0;
    endcase
  end

  always_comb begin
    mac_ctrl.mul_en = (state == S_MUL);
    mac_ctrl.acc_en = (state == S_ACC);
    mac_ctrl.clr    = !is_b_step || (step == STEP_IDX);
    mac_ctrl.sub    = (step == STEP_Y1_B) || (step == STEP_Z2_B);
  end

  rpzp_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .a    (mac_a),
    .b    (mac_b),
    .acc  (acc)
  );

  assign zv_now  = signed'(A_W'(signed'(acc[30:14]))) +
                   signed'({4'b0, view_distance, 8'b0});
  assign zv_pos  = !zv_now[17] && (zv_now != '0);
  assign neg_now = acc[DVD_W-1];
  assign mag_now = neg_now ? (~acc[DVD_W-1:0] + 1'b1) : acc[DVD_W-1:0];
  assign idx_now = acc[IDX_W-1:0] + {8'b0, col};

  assign div_start = (state == S_POST) &&
                     (((step == STEP_Z2_B) && zv_pos) ||
                      (step == STEP_COL_B) || (step == STEP_ROW_B));
  assign div_dividend = (step == STEP_Z2_B) ? (DVD_W'(1) << 24) : mag_now;
  assign div_divisor  = (step == STEP_Z2_B) ? zv_now[DVS_W-1:0] : zv[DVS_W-1:0];

  rpzp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign q_zero = (div_q == '0);
  assign col_ok = (!neg || q_zero) && (div_q < DVD_W'(screen_cols));
  assign row_ok = (!neg || q_zero) && (div_q < DVD_W'(screen_rows));

  assign cell_idx = IDX_W'(cell_index);
  assign plot_hit = (inv > rd_depth);

  always_comb begin
    store_req.rd_en    = (state == S_PLOT_RD) || (state == S_READ_RD);
    store_req.wr_en    = ((state == S_PLOT_CMP) && plot_hit) ||
                         ((state == S_READ_OUT) && !oor);
    store_req.addr     = addr;
    store_req.wr_glyph = (state == S_READ_OUT) ? GLYPH_BLANK : glyph_of(face_r);
    store_req.wr_depth = (state == S_READ_OUT) ? 16'd0 : inv;
  end

  rpzp_store u_store (
    .clk       (clk),
    .rst       (rst),
    .req       (store_req),
    .init_busy (init_busy),
    .rd_glyph  (rd_glyph),
    .rd_depth  (rd_depth)
  );

  assign result_strobe = (state == S_READ_OUT);
  assign glyph         = oor ? GLYPH_BLANK : rd_glyph;
  assign depth_value   = oor ? 16'd0 : rd_depth;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = cmd ? S_READ_RD : S_MUL;
        end
      end
      S_MUL:  state_next = S_ACC;
      S_ACC:  state_next = is_b_step ? S_POST : S_MUL;
      S_POST: begin
        case (step)
          STEP_Y1_B, STEP_Z1_B, STEP_X2_B: state_next = S_MUL;
          STEP_Z2_B:  state_next = zv_pos ? S_DIV : S_IDLE;
          STEP_COL_B, STEP_ROW_B:          state_next = S_DIV;
          STEP_IDX:   state_next = (32'(idx_now) >= MAX_CELLS) ? S_IDLE : S_PLOT_RD;
          default:    state_next = S_IDLE;
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          case (step)
            STEP_Z2_B:  state_next = S_MUL;
            STEP_COL_B: state_next = col_ok ? S_MUL : S_IDLE;
            STEP_ROW_B: state_next = row_ok ? S_MUL : S_IDLE;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_PLOT_RD:  state_next = S_PLOT_CMP;
      S_PLOT_CMP: state_next = S_IDLE;
      S_READ_RD:  state_next = S_READ_OUT;
      S_READ_OUT: state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= STEP_Y1_A;
    end else begin
      state <= state_next;
      if (state == S_IDLE) begin
        step <= STEP_Y1_A;
      end else if ((state == S_ACC) && !is_b_step) begin
        step <= step + 1'b1;
      end else if ((state == S_POST) && (state_next == S_MUL)) begin
        step <= step + 1'b1;
      end else if ((state == S_DIV) && (state_next == S_MUL)) begin
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px     <= point_x;
      py     <= point_y;
      pz     <= point_z;
      face_r <= face;
      addr   <= cell_idx[ADDR_W-1:0];
      oor    <= (32'(cell_index) >= MAX_CELLS);
    end
    if (state == S_POST) begin
      case (step)
        STEP_Y1_B:  y1 <= acc[29:14];
        STEP_Z1_B:  z1 <= acc[29:14];
        STEP_X2_B:  x2 <= acc[30:14];
        STEP_Z2_B:  zv <= zv_now;
        STEP_COL_B, STEP_ROW_B: neg <= neg_now;
        STEP_IDX:   addr <= idx_now[ADDR_W-1:0];
        default: ;
      endcase
    end
    if ((state == S_DIV) && div_done) begin
      case (step)
        STEP_Z2_B:  inv <= (|div_q[DVD_W-1:16]) ? 16'hFFFF : div_q[15:0];
        STEP_COL_B: col <= div_q[7:0];
        STEP_ROW_B: row <= div_q[6:0];
        default: ;
      endcase
    end
  end

endmodule

@@ design/rpzp_checker.sv @@
// Port-level checker for the plotter, bound to the top level.
module rpzp_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        cmd,
  input logic        result_strobe,
  input logic [7:0]  glyph,
  input logic [15:0] depth_value
);

  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    result_strobe |=> !result_strobe)
    else $error("result strobe held more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after transfer");

  a_read_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd) |=> ##1 result_strobe)
    else $error("read transfer gave no result on time");

  a_empty_cell: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && (depth_value == 16'd0)) |-> (glyph == 8'd32))
    else $error("empty cell returned a glyph other than blank");

endmodule

bind rotate_project_zbuffer_plot rpzp_checker u_checker (.*);

@@ test/tb_rotate_project_zbuffer_plot.sv @@
// Testbench for rotate_project_zbuffer_plot: queued traffic, z-buffer predictor, read-back checks.
`timescale 1ns / 100ps

module tb_rotate_project_zbuffer_plot;
  import rpzp_pkg::*;

  localparam logic CMD_PLOT = 1'b0;
  localparam logic CMD_READ = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  localparam int ITEM_TARGET = 900;
  localparam int TAIL_START  = 780;
  localparam int QUIET_MIN   = 160;
  localparam int TAIL_WAIT   = 200;
  localparam int CYCLE_LIMIT = 800000;
  localparam int HIT_KEEP    = 48;

  localparam logic [7:0] FACE_GLYPH [8] = '{8'h2E, 8'h3A, 8'h2D, 8'h3D,
                                            8'h2B, 8'h2A, 8'h23, 8'h25};
  localparam int COS_TAB [5] = '{16384, 14189, 11585, 8192, 0};
  localparam int SIN_TAB [5] = '{0, 8192, 11585, 14189, 16384};

  typedef struct packed {
    logic signed [15:0] cos_a;
    logic signed [15:0] sin_a;
    logic signed [15:0] cos_b;
    logic signed [15:0] sin_b;
    logic [7:0]         cols;
    logic [6:0]         rows;
    logic [5:0]         view_dist;
  } view_cfg_t;

  localparam view_cfg_t VIEW_RESET = '{16384, 0, 16384, 0, 80, 24, 30};

  typedef enum logic [1:0] {STEP_ITEM, STEP_REG, STEP_DRAIN} step_kind_t;

  typedef struct {
    step_kind_t             kind;
    logic                   cmd;
    logic signed [12:0]     px;
    logic signed [12:0]     py;
    logic signed [12:0]     pz;
    logic [2:0]             face;
    logic [12:0]            cell_no;
    logic [CFG_IDX_W-1:0]   reg_index;
    logic [15:0]            reg_data;
    int unsigned            gap;
  } step_t;

  typedef struct packed {
    logic [7:0]  glyph;
    logic [15:0] depth;
  } cell_readout_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 cmd = CMD_PLOT;
  logic signed [12:0]   point_x = '0;
  logic signed [12:0]   point_y = '0;
  logic signed [12:0]   point_z = '0;
  logic [2:0]           face = '0;
  logic [12:0]          cell_index = '0;
  logic                 result_strobe;
  logic [7:0]           glyph;
  logic [15:0]          depth_value;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_COS_FIRST;
  logic [15:0]          cfg_data = '0;

  rotate_project_zbuffer_plot u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .point_x       (point_x),
    .point_y       (point_y),
    .point_z       (point_z),
    .face          (face),
    .cell_index    (cell_index),
    .result_strobe (result_strobe),
    .glyph         (glyph),
    .depth_value   (depth_value),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  step_t         step_q[$];
  cell_readout_t readout_q[$];
  logic [7:0]    glyph_mem [MAX_CELLS];
  logic [15:0]   depth_mem [MAX_CELLS];
  view_cfg_t     view_now;
  view_cfg_t     view_plan = VIEW_RESET;
  int            hit_cells[$];
  bit            idle_phase;
  int            items_made;
  int            fail_count;
  int            cycle_count;
  bit            drained = 1'b1;
  int            quiet_count;
  step_t         cur;
  bit            have_step;
  int unsigned   gap_left;
  logic signed [12:0] last_x, last_y, last_z;

  function automatic void write_view_reg(inout view_cfg_t v, input logic [CFG_IDX_W-1:0] idx,
                                         input logic [15:0] d);
    case (idx)
      CFG_COS_FIRST:     v.cos_a = d;
      CFG_SIN_FIRST:     v.sin_a = d;
      CFG_COS_SECOND:    v.cos_b = d;
      CFG_SIN_SECOND:    v.sin_b = d;
      CFG_SCREEN_COLS:   v.cols = d[7:0];
      CFG_SCREEN_ROWS:   v.rows = d[6:0];
      CFG_VIEW_DISTANCE: v.view_dist = d[5:0];
      default: ;
    endcase
  endfunction

  // Rotate, shift by the view distance and project; returns whether a store cell is hit.
  function automatic bit project_point(input view_cfg_t v,
                                       input logic signed [12:0] px, py, pz,
                                       output int cell_no, output logic [15:0] inv);
    longint x, y, z, ca, sa, cb, sb, y1, z1, x2, z2, vdist, zv, q, col, row, ncols, nrows;
    x = longint'(px);
    y = longint'(py);
    z = longint'(pz);
    ca = longint'($signed(v.cos_a));
    sa = longint'($signed(v.sin_a));
    cb = longint'($signed(v.cos_b));
    sb = longint'($signed(v.sin_b));
    ncols = longint'(v.cols);
    nrows = longint'(v.rows);
    vdist = longint'(v.view_dist);
    cell_no = 0;
    inv = '0;
    y1 = (y * ca - z * sa) >>> 14;
    z1 = (y * sa + z * ca) >>> 14;
    x2 = (x * cb + z1 * sb) >>> 14;
    z2 = (z1 * cb - x * sb) >>> 14;
    zv = z2 + vdist * 256;
    if (zv <= 0) return 1'b0;
    q = 16777216 / zv;
    if (q > 65535) q = 65535;
    col = ((ncols / 2) * zv + 80 * x2) / zv;
    row = ((nrows / 2) * zv + 20 * y1) / zv;
    if (col < 0 || col >= ncols || row < 0 || row >= nrows) return 1'b0;
    if (col + row * ncols >= MAX_CELLS) return 1'b0;
    cell_no = int'(col + row * ncols);
    inv = q[15:0];
    return 1'b1;
  endfunction

  function automatic int unsigned next_gap();
    if (!idle_phase || items_made >= TAIL_START) return 0;
    if ($urandom_range(0, 9) < 3) return $urandom_range(1, 5);
    return 0;
  endfunction

  function automatic step_t fresh_step(input step_kind_t kind);
    step_t s;
    s.kind = kind;
    s.cmd = CMD_PLOT;
    s.px = 13'($urandom);
    s.py = 13'($urandom);
    s.pz = 13'($urandom);
    s.face = 3'($urandom_range(0, 7));
    s.cell_no = 13'($urandom_range(0, MAX_CELLS - 1));
    s.reg_index = CFG_COS_FIRST;
    s.reg_data = '0;
    s.gap = next_gap();
    return s;
  endfunction

  task automatic add_plot(input int x, input int y, input int z, input int f);
    step_t s;
    int c;
    logic [15:0] d;
    s = fresh_step(STEP_ITEM);
    s.px = 13'(x);
    s.py = 13'(y);
    s.pz = 13'(z);
    s.face = 3'(f);
    if (project_point(view_plan, s.px, s.py, s.pz, c, d)) begin
      hit_cells.push_back(c);
      if (hit_cells.size() > HIT_KEEP) void'(hit_cells.pop_front());
    end
    last_x = s.px;
    last_y = s.py;
    last_z = s.pz;
    step_q.push_back(s);
    items_made++;
  endtask

  task automatic add_read(input int c);
    step_t s;
    s = fresh_step(STEP_ITEM);
    s.cmd = CMD_READ;
    s.cell_no = 13'(c);
    step_q.push_back(s);
    items_made++;
  endtask

  task automatic add_reg(input logic [CFG_IDX_W-1:0] idx, input int d);
    step_t s;
    s = fresh_step(STEP_REG);
    s.reg_index = idx;
    s.reg_data = 16'(d);
    write_view_reg(view_plan, idx, s.reg_data);
    step_q.push_back(s);
  endtask

  task automatic add_drain();
    step_q.push_back(fresh_step(STEP_DRAIN));
  endtask

  task automatic pick_view();
    int a, v;
    if ($urandom_range(0, 1)) begin
      a = $urandom_range(0, 4);
      add_reg(CFG_COS_FIRST, $urandom_range(0, 1) ? -COS_TAB[a] : COS_TAB[a]);
      add_reg(CFG_SIN_FIRST, $urandom_range(0, 1) ? -SIN_TAB[a] : SIN_TAB[a]);
    end
    if ($urandom_range(0, 1)) begin
      a = $urandom_range(0, 4);
      add_reg(CFG_COS_SECOND, $urandom_range(0, 1) ? -COS_TAB[a] : COS_TAB[a]);
      add_reg(CFG_SIN_SECOND, $urandom_range(0, 1) ? -SIN_TAB[a] : SIN_TAB[a]);
    end
    if ($urandom_range(0, 7) == 0) add_reg(3'($urandom_range(0, 3)), $urandom);
    if ($urandom_range(0, 2) == 0) begin
      case ($urandom_range(0, 7))
        0: v = 1;
        1: v = 128;
        2: v = $urandom_range(0, 1) ? 0 : 255;
        default: v = $urandom_range(1, 128);
      endcase
      add_reg(CFG_SCREEN_COLS, ($urandom & 32'hFF00) | v);
    end
    if ($urandom_range(0, 2) == 0) begin
      case ($urandom_range(0, 7))
        0: v = 1;
        1: v = 64;
        2: v = $urandom_range(0, 1) ? 0 : 127;
        default: v = $urandom_range(1, 64);
      endcase
      add_reg(CFG_SCREEN_ROWS, ($urandom & 32'hFF80) | v);
    end
    if ($urandom_range(0, 2) == 0) begin
      case ($urandom_range(0, 7))
        0: v = 1;
        1: v = 63;
        2: v = 0;
        default: v = $urandom_range(1, 63);
      endcase
      add_reg(CFG_VIEW_DISTANCE, ($urandom & 32'hFFC0) | v);
    end
  endtask

  initial begin : stim_build
    int len, r, m;
    idle_phase = 1'b1;

    add_plot(0, 0, 0, 0);
    add_plot(0, 0, 0, 1);
    add_read(1000);
    add_read(1000);
    add_plot(4095, 4095, 4095, 5);
    add_plot(-4096, -4096, -4096, 7);
    add_plot(4095, -4096, 0, 6);
    add_drain();
    add_read(1507);
    add_plot(-3900, 0, 0, 3);
    add_plot(-3936, 0, 0, 4);
    add_read(960);

    add_reg(CFG_VIEW_DISTANCE, 1);
    add_plot(0, 0, -4096, 0);
    add_plot(0, 0, -256, 1);
    add_plot(0, 0, 0, 2);
    add_plot(0, 0, 0, 3);
    add_read(1000);

    add_reg(CFG_SCREEN_COLS, 128);
    add_reg(CFG_SCREEN_ROWS, 64);
    add_reg(CFG_VIEW_DISTANCE, 30);
    add_reg(CFG_COS_FIRST, 0);
    add_reg(CFG_SIN_FIRST, 16384);
    add_reg(CFG_COS_SECOND, -16384);
    add_reg(CFG_SIN_SECOND, 0);
    add_plot(0, 0, 0, 4);
    add_read(4160);
    add_plot(0, 0, 4095, 5);
    add_read(2752);

    add_reg(CFG_SCREEN_COLS, 255);
    add_reg(CFG_SCREEN_ROWS, 127);
    add_reg(CFG_VIEW_DISTANCE, 63);
    add_reg(CFG_COS_SECOND, 0);
    add_reg(CFG_SIN_SECOND, 16384);
    add_reg(CFG_UNUSED, 16'h5A5A);
    add_plot(0, 0, 0, 2);
    add_read(MAX_CELLS - 1);
    add_read(0);

    add_reg(CFG_SCREEN_COLS, 80);
    add_reg(CFG_SCREEN_ROWS, 24);
    add_reg(CFG_VIEW_DISTANCE, 30);

    while (items_made < ITEM_TARGET) begin
      idle_phase = $urandom_range(0, 1);
      if ($urandom_range(0, 3) == 0) add_drain();
      pick_view();
      hit_cells.delete();
      len = $urandom_range(30, 90);
      repeat (len) begin
        if ($urandom_range(0, 59) == 0) add_drain();
        if ($urandom_range(0, 99) < 35) begin
          if (hit_cells.size() != 0 && $urandom_range(0, 3) != 0)
            add_read(hit_cells[$urandom_range(0, hit_cells.size() - 1)]);
          else
            add_read($urandom_range(0, MAX_CELLS - 1));
        end else begin
          r = $urandom_range(0, 9);
          if (r < 6) begin
            m = $urandom_range(1, 6) * 256;
            add_plot(int'($urandom_range(0, 2 * m)) - m, int'($urandom_range(0, 2 * m)) - m,
                     int'($urandom_range(0, 2 * m)) - m, $urandom_range(0, 7));
          end else if (r == 6) begin
            add_plot(last_x, last_y, last_z, $urandom_range(0, 7));
          end else begin
            add_plot(int'($urandom_range(0, 8191)) - 4096, int'($urandom_range(0, 8191)) - 4096,
                     int'($urandom_range(0, 8191)) - 4096, $urandom_range(0, 7));
          end
        end
      end
    end
  end

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      have_step = 1'b0;
      gap_left = 0;
    end else if (start) begin
      if (!busy) begin
        start <= 1'b0;
        have_step = 1'b0;
      end
    end else if (cfg_valid) begin
      if (cfg_ready) begin
        cfg_valid <= 1'b0;
        have_step = 1'b0;
      end
    end else begin
      if (!have_step && step_q.size() != 0) begin
        cur = step_q.pop_front();
        have_step = 1'b1;
        gap_left = cur.gap;
      end
      if (have_step) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
        end else begin
          case (cur.kind)
            STEP_ITEM: begin
              start <= 1'b1;
              cmd <= cur.cmd;
              point_x <= cur.px;
              point_y <= cur.py;
              point_z <= cur.pz;
              face <= cur.face;
              cell_index <= cur.cell_no;
            end
            STEP_REG: begin
              if (drained && quiet_count >= QUIET_MIN) begin
                cfg_valid <= 1'b1;
                cfg_index <= cur.reg_index;
                cfg_data <= cur.reg_data;
              end
            end
            default: begin
              if (drained) have_step = 1'b0;
            end
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin : readback_check
    cell_readout_t want;
    int c;
    logic [15:0] d;
    if (rst) begin
      view_now = VIEW_RESET;
      for (int i = 0; i < MAX_CELLS; i++) begin
        glyph_mem[i] = GLYPH_BLANK;
        depth_mem[i] = '0;
      end
      readout_q.delete();
      drained <= 1'b1;
      quiet_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) write_view_reg(view_now, cfg_index, cfg_data);
      if (start && !busy) begin
        if (cmd == CMD_READ) begin
          want.glyph = glyph_mem[cell_index];
          want.depth = depth_mem[cell_index];
          readout_q.push_back(want);
          glyph_mem[cell_index] = GLYPH_BLANK;
          depth_mem[cell_index] = '0;
        end else if (project_point(view_now, point_x, point_y, point_z, c, d)) begin
          if (d > depth_mem[c]) begin
            depth_mem[c] = d;
            glyph_mem[c] = FACE_GLYPH[face];
          end
        end
      end
      if (result_strobe) begin
        if (readout_q.size() == 0) begin
          $error("unexpected result: glyph %0d depth_value %0d", glyph, depth_value);
          fail_count++;
        end else begin
          want = readout_q.pop_front();
          if (glyph !== want.glyph) begin
            $error("glyph: expected %0d, got %0d", want.glyph, glyph);
            fail_count++;
          end
          if (depth_value !== want.depth) begin
            $error("depth_value: expected %0d, got %0d", want.depth, depth_value);
            fail_count++;
          end
        end
      end
      drained <= (readout_q.size() == 0);
      quiet_count <= (busy || start) ? 0 : quiet_count + 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    do @(negedge clk);
    while (step_q.size() != 0 || have_step || start || cfg_valid || readout_q.size() != 0);
    repeat (TAIL_WAIT) @(negedge clk);
    if (readout_q.size() != 0) begin
      $error("readout: %0d expected results never arrived", readout_q.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
